// File: rtl/lpks_pkg.sv
// Package for the linear-probe key set: request and status codes,
// sequencer states and default sizes. No dependencies.
package lpks_pkg;

	localparam int TABLE_SIZE_DEF = 1024;
	localparam int KEY_BITS_DEF   = 64;
	localparam int HASH_SHIFT     = 2;
	localparam int COUNT_W        = 11;
	localparam int IN_TDATA_W     = 72;
	localparam int OUT_TDATA_W    = 16;

	localparam logic [1:0] REQ_ADD = 2'd0;
	localparam logic [1:0] REQ_HAS = 2'd1;
	localparam logic [1:0] REQ_REM = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NULL     = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_CHECK,
		S_WRITE,
		S_RESP
	} seq_state_t;

endpackage

// File: rtl/lpks_home.sv
// Home slot unit: (key >> HASH_SHIFT) mod TABLE_SIZE.
// Power-of-two sizes take the low bits, registered; others fold 16-bit chunks, then reduce.
// Depends on lpks_pkg.
module lpks_home import lpks_pkg::*; #(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int IW         = $clog2(TABLE_SIZE)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [KEY_BITS-1:0] key,
	output logic                done,
	output logic [IW-1:0]       home
);

	localparam int SW = (KEY_BITS - HASH_SHIFT > IW) ? KEY_BITS - HASH_SHIFT : IW;

	logic [SW-1:0] shifted;
	logic [IW-1:0] r_q;
	logic          done_q;

	assign shifted = SW'(key >> HASH_SHIFT);
	assign done    = done_q;
	assign home    = r_q;

	generate
		if ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0) begin : g_pow2
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					r_q <= shifted[IW-1:0];
				end
			end
		end else begin : g_fold
			// sum of 16-bit chunks times 2^(16k) mod size, then one reciprocal
			// multiply; the estimate is at most one low, so one subtract fixes it
			localparam int NCH = (SW + 15) / 16;
			localparam int PW  = NCH * 16;
			localparam int NST = NCH + 2;
			localparam int CNW = $clog2(NST);
			localparam int AW  = 34;

			function automatic logic [15:0] chunk_weight(int k);
				logic [63:0] w;
				w = 64'd1;
				for (int j = 0; j < k; j++) begin
					w = (w << 16) % 64'(TABLE_SIZE);
				end
				return w[15:0];
			endfunction

			localparam logic [3:0][15:0] WTS = {chunk_weight(3), chunk_weight(2),
				chunk_weight(1), chunk_weight(0)};
			localparam logic [31:0] RECIP   = 32'((64'd1 << AW) / 64'(TABLE_SIZE));
			localparam logic [15:0] MODULUS = 16'(TABLE_SIZE);

			logic [PW-1:0]  sh_q;
			logic [AW-1:0]  acc_q;
			logic [31:0]    q_q;
			logic [CNW-1:0] step_q;
			logic           busy_q;
			logic [31:0]    part;
			logic [65:0]    qprod;
			logic [47:0]    mprod;
			logic [AW-1:0]  diff;
			logic [AW-1:0]  rfix;

			assign part  = {16'b0, sh_q[15:0]} * {16'b0, WTS[step_q[1:0]]};
			assign qprod = {32'b0, acc_q} * {34'b0, RECIP};
			assign mprod = {16'b0, q_q} * {32'b0, MODULUS};
			assign diff  = acc_q - mprod[AW-1:0];
			assign rfix  = (diff >= AW'(TABLE_SIZE)) ? diff - AW'(TABLE_SIZE) : diff;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					step_q <= '0;
				end else begin
					done_q <= busy_q && (step_q == CNW'(NST - 1));
					if (start) begin
						busy_q <= 1'b1;
						step_q <= '0;
					end else if (busy_q) begin
						if (step_q == CNW'(NST - 1)) begin
							busy_q <= 1'b0;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					sh_q  <= PW'(shifted);
					acc_q <= '0;
				end else if (busy_q) begin
					if (step_q < CNW'(NCH)) begin
						acc_q <= acc_q + AW'(part);
						sh_q  <= sh_q >> 16;
					end else if (step_q == CNW'(NCH)) begin
						q_q <= qprod[65:AW];
					end else begin
						r_q <= rfix[IW-1:0];
					end
				end
			end
		end
	endgenerate

endmodule

// File: rtl/lpks_slot_ram.sv
// Slot table memory: one port, read or write each cycle, registered read.
// Depends on lpks_pkg.
module lpks_slot_ram import lpks_pkg::*; #(
	parameter int DEPTH = TABLE_SIZE_DEF,
	parameter int WIDTH = KEY_BITS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

endmodule

// File: rtl/linear_probe_key_set_top.sv
// Linear-probe key set: top level with the probe sequencer.
// Reset: a clearing pass writes one slot per cycle over all TABLE_SIZE slots (1024 by default),
// with s_tready low. Per request: an accept state, the home slot unit (folding for non-power-of-two
// sizes), a probe and a check state per slot probed (one memory port), a write state for an
// add or remove that changes the table, then a result state that waits for the output to be free.
// One request at a time. Depends on lpks_pkg, lpks_home, lpks_slot_ram.
module linear_probe_key_set_top import lpks_pkg::*; #(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // req_type[1:0], key[65:2], zero pad
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // ok[0], status[2:1], entry_count[13:3], pad
);

	localparam int IW  = $clog2(TABLE_SIZE);
	localparam int CWN = $clog2(TABLE_SIZE + 1);
	localparam int CW  = (CWN > COUNT_W) ? CWN : COUNT_W;

	seq_state_t state_q, state_d;

	logic [IW-1:0]       clr_q;
	logic [1:0]          req_q;
	logic [KEY_BITS-1:0] key_q;
	logic [IW-1:0]       home_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       free_q;
	logic                have_free_q;
	logic                at_home_q;
	logic                ok_q;
	logic [1:0]          st_q;
	logic [CW-1:0]       cnt_q;
	logic                m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic                in_xfer;
	logic [1:0]          in_req;
	logic [KEY_BITS-1:0] in_key;
	logic                home_start;
	logic                home_done;
	logic [IW-1:0]       home_idx;
	logic                ram_we;
	logic [IW-1:0]       ram_addr;
	logic [KEY_BITS-1:0] ram_wdata;
	logic [KEY_BITS-1:0] ram_rdata;
	logic [IW-1:0]       next_idx;
	logic                hit;
	logic                empty;
	logic                scan_end;
	logic                out_free;

	assign in_xfer  = s_tvalid && s_tready;
	assign in_req   = (s_tdata[1:0] == REQ_ADD || s_tdata[1:0] == REQ_REM) ?
	                  s_tdata[1:0] : REQ_HAS;
	assign in_key   = s_tdata[KEY_BITS+1:2];
	assign next_idx = (idx_q == IW'(TABLE_SIZE - 1)) ? '0 : idx_q + 1'b1;
	assign hit      = (ram_rdata == key_q);
	assign empty    = (ram_rdata == '0);
	assign scan_end = (next_idx == home_q);
	assign out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	lpks_home #(
		.TABLE_SIZE(TABLE_SIZE),
		.KEY_BITS  (KEY_BITS),
		.IW        (IW)
	) u_home (
		.clk   (clk),
		.arst_n(arst_n),
		.start (home_start),
		.key   (in_key),
		.done  (home_done),
		.home  (home_idx)
	);

	lpks_slot_ram #(
		.DEPTH(TABLE_SIZE),
		.WIDTH(KEY_BITS),
		.AW   (IW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == IW'(TABLE_SIZE - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_xfer) state_d = (in_key == '0) ? S_RESP : S_HASH;
			end
			S_HASH: begin
				if (home_done) state_d = S_PROBE;
			end
			S_PROBE: state_d = S_CHECK;
			S_CHECK: begin
				if (hit) begin
					state_d = (req_q == REQ_REM) ? S_WRITE : S_RESP;
				end else if (at_home_q && empty) begin
					state_d = (req_q == REQ_ADD) ? S_WRITE : S_RESP;
				end else if (scan_end) begin
					state_d = (req_q == REQ_ADD && (have_free_q || empty)) ? S_WRITE : S_RESP;
				end else begin
					state_d = S_PROBE;
				end
			end
			S_WRITE: state_d = S_RESP;
			S_RESP: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready   = 1'b0;
		home_start = 1'b0;
		ram_we     = 1'b0;
		ram_addr   = idx_q;
		ram_wdata  = (req_q == REQ_ADD) ? key_q : '0;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			S_IDLE: begin
				s_tready   = 1'b1;
				home_start = s_tvalid && (in_key != '0);
			end
			S_WRITE: ram_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == S_WRITE) begin
				if (req_q == REQ_ADD) begin
					cnt_q <= cnt_q + 1'b1;
				end else if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			if (state_q == S_RESP && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q       <= in_req;
				key_q       <= in_key;
				ok_q        <= 1'b0;
				st_q        <= (in_key == '0) ? ST_NULL : ST_MISMATCH;
				have_free_q <= 1'b0;
				at_home_q   <= 1'b1;
			end
			S_HASH: begin
				home_q <= home_idx;
				idx_q  <= home_idx;
			end
			S_CHECK: begin
				at_home_q <= 1'b0;
				if (hit) begin
					if (req_q == REQ_HAS) begin
						ok_q <= 1'b1;
						st_q <= ST_OK;
					end
				end else if (at_home_q && empty) begin
					// empty home: absent, and the home slot takes an add
				end else if (scan_end) begin
					if (req_q == REQ_ADD) begin
						if (have_free_q) begin
							idx_q <= free_q;
						end else if (!empty) begin
							st_q <= ST_FULL;
						end
					end
				end else begin
					idx_q <= next_idx;
					if (empty && !have_free_q) begin
						free_q      <= idx_q;
						have_free_q <= 1'b1;
					end
				end
			end
			S_WRITE: begin
				ok_q <= 1'b1;
				st_q <= ST_OK;
			end
			S_RESP: begin
				if (out_free) begin
					m_tdata_q <= {2'b00, cnt_q[COUNT_W-1:0], st_q, ok_q};
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_SIZE))
		else $error("held count above table size");

	a_ok_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == ST_OK)))
		else $error("ok flag disagrees with status");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_tready)
		else $error("second request taken while one is in flight");

	a_no_write_while_probing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE || state_q == S_CHECK) |-> !ram_we)
		else $error("slot write during probe");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> (idx_q <= IW'(TABLE_SIZE - 1)))
		else $error("write index outside table");
`endif

endmodule
